// ===== sv/slm_pkg.sv =====
// slm_pkg: types, constants and helper functions for the spectral low-pass mask
// used by slm_isqrt and spectral_lowpass_mask; no dependencies
package slm_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int MIN_SIZE   = 2;
  localparam int GRID_W     = 11;
  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int CUTOFF_W   = 20;
  localparam int RECIP_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = FRAC_W + 1;
  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1) << FRAC_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // radial wavenumber square root
  localparam int S_W       = 21;                // kx^2 + ky^2
  localparam int ROOT_W    = 19;                // floor(sqrt(s << 16))
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int SQ_PER    = 4;
  localparam int SQ_STAGES = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int VV_W      = 2 * SQ_STEPS;

  localparam int PROD_W    = ROOT_W + RECIP_W;
  localparam int POLY_W    = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_CUTOFF     = 2'd1,
    REG_SMOOTH     = 2'd2,
    REG_RECIP      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GS_PASS = 2'd0,
    GS_ZERO = 2'd1,
    GS_POLY = 2'd2
  } gain_sel_t;

  typedef struct packed {
    logic [IDX_W-1:0]         bin_row;
    logic [IDX_W-1:0]         bin_col;
    logic signed [DATA_W-1:0] bin_real;
    logic signed [DATA_W-1:0] bin_imag;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_real;
    logic signed [DATA_W-1:0] out_imag;
  } out_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one restoring square-root step, consumes two radicand bits
  function automatic sq_t sqrt_step(sq_t a, logic [1:0] pr);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] tr;
    sq_t              o;
    r  = {a.rem[REM_W-3:0], pr};
    tr = REM_W'({a.root, 2'b01});
    if (r >= tr) begin
      o.rem  = r - tr;
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== sv/slm_isqrt.sv =====
// slm_isqrt: pipelined integer square root of (s << 16), up to four root bits per stage
// depends on slm_pkg
module slm_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [slm_pkg::S_W-1:0]    s_in,
  output logic [slm_pkg::ROOT_W-1:0] root
);
  import slm_pkg::*;

  sq_t            st_r [SQ_STAGES];
  logic [S_W-1:0] sv_r [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
    sq_t            a;
    sq_t            st_nxt;
    logic [S_W-1:0] sv;

    if (g == 0) begin : g_first
      assign a  = '0;
      assign sv = s_in;
    end else begin : g_rest
      assign a  = st_r[g-1];
      assign sv = sv_r[g-1];
    end

    always_comb begin
      logic [VV_W-1:0] vv;
      vv     = VV_W'({sv, {FRAC_W{1'b0}}});
      st_nxt = a;
      for (int j = 0; j < SQ_PER; j++) begin
        if (g * SQ_PER + j < SQ_STEPS) begin
          st_nxt = sqrt_step(st_nxt, vv[2 * (SQ_STEPS - 1 - (g * SQ_PER + j)) +: 2]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt;
        sv_r[g] <= sv;
      end
    end
  end

  assign root = st_r[SQ_STAGES-1].root;

endmodule

// ===== sv/spectral_lowpass_mask.sv =====
// spectral_lowpass_mask: radial low-pass mask for half-spectrum bins of a 2-D FFT
// depends on slm_pkg and slm_isqrt
//
// usage:
//   input channel in_valid / in_stall / in_data carries one bin (row, column,
//   real and imaginary part); output channel out_valid / out_stall / out_data
//   returns the same bin scaled by the mask gain, in order, one per input.
//   the cfg port (cfg_we, cfg_addr, cfg_wdata) writes grid size, cutoff,
//   smooth mode and the transition reciprocal; write only while idle.
// throughput: one bin per cycle unless out_stall holds the pipeline; the
//   14-stage pipeline holds one bin per stage (fold and square, five
//   square-root stages, distance and gain select, ramp multiply, ramp clamp,
//   three stages of smoothstep products, gain select, final scale multiply).
// stall: while out_valid is high and out_stall is high the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
// reset: synchronous active-low rst_n clears all valid bits and loads the
//   register defaults (n = 1024, cutoff 128.0, hard mode, reciprocal zero).
module spectral_lowpass_mask (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  slm_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output slm_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [slm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [slm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slm_pkg::*;

  localparam int NST = SQ_STAGES + 9;
  localparam int ST_SQ  = SQ_STAGES + 1;  // diff / select stage
  localparam int ST_PR  = ST_SQ + 1;
  localparam int ST_T   = ST_PR + 1;
  localparam int ST_X2  = ST_T + 1;
  localparam int ST_X34 = ST_X2 + 1;
  localparam int ST_G   = ST_X34 + 1;
  localparam int ST_GN  = ST_G + 1;

  // configuration
  logic [GRID_W-1:0]   grid_r;
  logic [CUTOFF_W-1:0] cutoff_r;
  logic                smooth_r;
  logic [RECIP_W-1:0]  recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r   <= GRID_W'(MAX_SIZE);
      cutoff_r <= CUTOFF_W'(32768);
      smooth_r <= 1'b0;
      recip_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_GRID_SIZE: grid_r   <= cfg_wdata[GRID_W-1:0];
        REG_CUTOFF:    cutoff_r <= cfg_wdata[CUTOFF_W-1:0];
        REG_SMOOTH:    smooth_r <= cfg_wdata[0];
        REG_RECIP:     recip_r  <= cfg_wdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves together
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv      = !vld_r[NST-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  in_t pl_r [NST-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= in_data;
      for (int i = 1; i < NST - 1; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
    end
  end

  // stage 0: fold row, squares
  logic [GRID_W-1:0] n_c;
  logic [IDX_W-1:0]  half_c;
  logic [IDX_W-1:0]  kx_c;
  logic [S_W-1:0]    s_nxt;
  logic [S_W-1:0]    s0_r;

  always_comb begin
    if (grid_r < GRID_W'(MIN_SIZE)) begin
      n_c = GRID_W'(MIN_SIZE);
    end else if (grid_r > GRID_W'(MAX_SIZE)) begin
      n_c = GRID_W'(MAX_SIZE);
    end else begin
      n_c = grid_r;
    end
    half_c = n_c[GRID_W-1:1];
    if (in_data.bin_row <= half_c) begin
      kx_c = in_data.bin_row;
    end else if (GRID_W'(in_data.bin_row) < n_c) begin
      kx_c = IDX_W'(n_c - GRID_W'(in_data.bin_row));
    end else begin
      kx_c = IDX_W'(GRID_W'(in_data.bin_row) - n_c);
    end
    s_nxt = S_W'(kx_c) * S_W'(kx_c)
          + S_W'(in_data.bin_col) * S_W'(in_data.bin_col);
  end

  always_ff @(posedge clk) begin
    if (adv) s0_r <= s_nxt;
  end

  // stages 1..SQ_STAGES: square root
  logic [ROOT_W-1:0] w_c;

  slm_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .s_in (s0_r),
    .root (w_c)
  );

  // ramp distance and gain selection
  gain_sel_t         sel_nxt;
  gain_sel_t         sel_r [ST_SQ:ST_GN-1];
  logic [ROOT_W-1:0] diff_r;
  logic              above_c;

  assign above_c = CUTOFF_W'(w_c) > cutoff_r;

  always_comb begin
    if (!above_c) begin
      sel_nxt = GS_PASS;
    end else if (!smooth_r) begin
      sel_nxt = GS_ZERO;
    end else if (recip_r == '0) begin
      sel_nxt = GS_PASS;
    end else begin
      sel_nxt = GS_POLY;
    end
  end

  // ramp product and clamp
  logic [PROD_W-1:0]   prod_r;
  logic [GAIN_W-1:0]   t_nxt;
  logic [GAIN_W-1:0]   t_r;
  logic [2*GAIN_W-1:0] m_x2;
  logic [GAIN_W-1:0]   x2_r;
  logic [GAIN_W-1:0]   t9_r;
  logic [2*GAIN_W-1:0] m_x3;
  logic [2*GAIN_W-1:0] m_x4;
  logic [GAIN_W-1:0]   x3_r;
  logic [GAIN_W-1:0]   x4_r;
  logic [GAIN_W-1:0]   x2b_r;
  logic [GAIN_W-1:0]   t10_r;
  logic [POLY_W-1:0]   pos_c;
  logic [POLY_W-1:0]   neg_c;
  logic [POLY_W-1:0]   g_r;
  logic [GAIN_W-1:0]   x4b_r;
  logic [GAIN_W+POLY_W-1:0] m_s;
  logic [POLY_W-1:0]   sm_c;
  logic [GAIN_W-1:0]   gain_nxt;
  logic [GAIN_W-1:0]   gain_r;

  always_comb begin
    if (|prod_r[PROD_W-1:2*FRAC_W]) begin
      t_nxt = '0;
    end else begin
      t_nxt = ONE_Q16 - GAIN_W'(prod_r[2*FRAC_W-1:FRAC_W]);
    end
  end

  assign m_x2  = t_r * t_r;
  assign m_x3  = x2_r * t9_r;
  assign m_x4  = x2_r * x2_r;
  assign pos_c = POLY_W'(35) * POLY_W'(ONE_Q16) + POLY_W'(70) * POLY_W'(x2b_r);
  assign neg_c = POLY_W'(84) * POLY_W'(t10_r) + POLY_W'(20) * POLY_W'(x3_r);
  assign m_s   = x4b_r * g_r;
  assign sm_c  = POLY_W'(m_s[GAIN_W+POLY_W-1:FRAC_W]);

  always_comb begin
    case (sel_r[ST_GN-1])
      GS_PASS: gain_nxt = ONE_Q16;
      GS_ZERO: gain_nxt = '0;
      GS_POLY: gain_nxt = (sm_c > POLY_W'(ONE_Q16)) ? ONE_Q16 : GAIN_W'(sm_c);
      default: gain_nxt = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r[ST_SQ] <= sel_nxt;
      for (int i = ST_SQ + 1; i < ST_GN; i++) begin
        sel_r[i] <= sel_r[i-1];
      end
      diff_r <= ROOT_W'(CUTOFF_W'(w_c) - cutoff_r);
      prod_r <= diff_r * recip_r;
      t_r    <= t_nxt;
      x2_r   <= m_x2[2*FRAC_W:FRAC_W];
      t9_r   <= t_r;
      x3_r   <= m_x3[2*FRAC_W:FRAC_W];
      x4_r   <= m_x4[2*FRAC_W:FRAC_W];
      x2b_r  <= x2_r;
      t10_r  <= t9_r;
      g_r    <= (pos_c > neg_c) ? pos_c - neg_c : '0;
      x4b_r  <= x4_r;
      gain_r <= gain_nxt;
    end
  end

  // final scale, arithmetic shift is floor division
  logic signed [DATA_W+GAIN_W:0] re_p;
  logic signed [DATA_W+GAIN_W:0] im_p;
  out_t                          out_r;
  in_t                           last_c;

  assign last_c = pl_r[NST-2];
  assign re_p   = last_c.bin_real * $signed({1'b0, gain_r});
  assign im_p   = last_c.bin_imag * $signed({1'b0, gain_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_row  <= last_c.bin_row;
      out_r.out_col  <= last_c.bin_col;
      out_r.out_real <= re_p[DATA_W+FRAC_W-1:FRAC_W];
      out_r.out_imag <= im_p[DATA_W+FRAC_W-1:FRAC_W];
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_GN] |-> gain_r <= ONE_Q16)
    else $error("mask gain above unity");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_hard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_GN-1] && adv && sel_r[ST_GN-1] == GS_ZERO) |=> gain_r == '0)
    else $error("hard mode did not zero the gain");
`endif

endmodule

// ===== sim/spectral_lowpass_mask_test.sv =====
// spectral_lowpass_mask_test: self-checking bench for the radial low-pass mask
// drives bins through valid/stall with random idling and checks each result
// against a local predictor; depends on slm_pkg and spectral_lowpass_mask
`timescale 1ns / 100ps

module spectral_lowpass_mask_test;
  import slm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 50;
  localparam int N_PHASES     = 8;
  localparam int N_DIR        = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spectral_lowpass_mask dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the mask registers
  logic [GRID_W-1:0]   m_grid = 11'd1024;
  logic [CUTOFF_W-1:0] m_cutoff = 20'd32768;
  logic                m_smooth = 1'b0;
  logic [RECIP_W-1:0]  m_recip = '0;

  out_t masked_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  typedef struct {
    in_t  bin;
    bit   typed;
    out_t want;
  } dir_row_t;
  dir_row_t dir_tab[N_DIR];

  function automatic longint unsigned radial_root(longint unsigned s);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned roll_off(longint unsigned x);
    longint unsigned x2, x3, x4, pos, neg, g, s;
    x2  = (x * x) >> 16;
    x3  = (x2 * x) >> 16;
    x4  = (x2 * x2) >> 16;
    pos = 35 * 65536 + 70 * x2;
    neg = 84 * x + 20 * x3;
    g   = pos > neg ? pos - neg : 0;
    s   = (x4 * g) >> 16;
    return s > 65536 ? 65536 : s;
  endfunction

  function automatic logic [DATA_W-1:0] apply_gain(logic signed [DATA_W-1:0] v,
                                                   longint unsigned gain);
    longint p;
    p = longint'(v) * longint'(gain);
    return DATA_W'(p >>> 16);
  endfunction

  function automatic out_t mask_bin(in_t b);
    longint unsigned n, half, w, gain, d, t, s;
    longint kx;
    out_t o;
    n = m_grid;
    if (n < MIN_SIZE) n = MIN_SIZE;
    if (n > MAX_SIZE) n = MAX_SIZE;
    half = n / 2;
    kx = (b.bin_row <= half) ? longint'(b.bin_row) : longint'(b.bin_row) - longint'(n);
    s = (unsigned'(kx * kx) + 64'(b.bin_col) * 64'(b.bin_col)) << 16;
    w = radial_root(s);
    gain = 65536;
    if (w > m_cutoff) begin
      if (!m_smooth) begin
        gain = 0;
      end else if (m_recip != 0) begin
        d = ((w - m_cutoff) * m_recip) >> 16;
        t = d >= 65536 ? 0 : 65536 - d;
        gain = roll_off(t);
      end
    end
    o.out_row  = b.bin_row;
    o.out_col  = b.bin_col;
    o.out_real = apply_gain(b.bin_real, gain);
    o.out_imag = apply_gain(b.bin_imag, gain);
    return o;
  endfunction

  // result check and input capture, both on the rising edge
  always @(posedge clk) begin
    out_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL spectral_lowpass_mask");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (masked_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer out: %h", out_data);
      end else begin
        want = masked_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want %0d %0d %h %h, got %0d %0d %h %h",
                     want.out_row, want.out_col, want.out_real, want.out_imag,
                     out_data.out_row, out_data.out_col, out_data.out_real,
                     out_data.out_imag);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_bin(in_t b, bit typed, out_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    masked_q.push_back(typed ? want : mask_bin(b));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GRID_SIZE: m_grid = val[GRID_W-1:0];
      REG_CUTOFF:    m_cutoff = val[CUTOFF_W-1:0];
      REG_SMOOTH:    m_smooth = val[0];
      REG_RECIP:     m_recip = val[RECIP_W-1:0];
      default:       ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic dir_row_t mk_row(int r, int c, logic [31:0] re, logic [31:0] im,
                                      bit typed, logic [31:0] wre, logic [31:0] wim);
    dir_row_t x;
    x.bin = '{bin_row: IDX_W'(r), bin_col: IDX_W'(c), bin_real: re, bin_imag: im};
    x.typed = typed;
    x.want = '{out_row: IDX_W'(r), out_col: IDX_W'(c), out_real: wre, out_imag: wim};
    return x;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    in_t  b;
    out_t none;
    int   n;
    int   half;
    int   grids[N_PHASES];
    int   cuts[N_PHASES];
    int   smooth[N_PHASES];
    int   recips[N_PHASES];

    grids  = '{1024, 16, 0, 2047, 64, 256, 8, 1};
    cuts   = '{32768, 1024, 0, 1048575, 2688, 0, 256, 768};
    smooth = '{1, 1, 1, 0, 1, 0, 1, 1};
    recips = '{43690, 4194304, 16777215, 0, 0, 65536, 16777215, 16777215};

    none = '0;
    // reset settings: n = 1024, cutoff 128.0, hard mode
    dir_tab[0] = mk_row(0, 0, 0, 0, 1, 0, 0);
    dir_tab[1] = mk_row(0, 0, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 32'h80000000);
    dir_tab[2] = mk_row(0, 512, 1, 32'hffffffff, 1, 0, 0);
    dir_tab[3] = mk_row(512, 0, 32'h12345678, 32'h9abcdef0, 1, 0, 0);
    dir_tab[4] = mk_row(513, 0, 7, 7, 1, 0, 0);
    dir_tab[5] = mk_row(1023, 1023, 32'hffffffff, 1, 1, 0, 0);
    dir_tab[6] = mk_row(128, 0, 5, 32'hfffffffb, 1, 5, 32'hfffffffb);
    dir_tab[7] = mk_row(129, 0, 5, 5, 1, 0, 0);
    dir_tab[8] = mk_row(90, 90, 32'h0000ffff, 32'hffff0000, 0, 0, 0);
    dir_tab[9] = mk_row(1000, 5, 32'h55555555, 32'haaaaaaaa, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_bin(dir_tab[i].bin, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(REG_GRID_SIZE, CFG_DATA_W'(grids[p]));
      write_reg(REG_CUTOFF, CFG_DATA_W'(cuts[p]));
      write_reg(REG_SMOOTH, CFG_DATA_W'(smooth[p]));
      write_reg(REG_RECIP, CFG_DATA_W'(recips[p]));
      case (p % 4)
        1: send_idle_pct = 56;
        2: stall_pct = 56;
        3: begin
          send_idle_pct = 17;
          stall_pct = 17;
        end
        default: ;
      endcase
      n = grids[p] < MIN_SIZE ? MIN_SIZE : (grids[p] > MAX_SIZE ? MAX_SIZE : grids[p]);
      half = n / 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly bins inside the grid, some anywhere in the index range
        if ($urandom_range(3) != 0) begin
          b.bin_row = IDX_W'($urandom_range(n - 1));
          b.bin_col = IDX_W'($urandom_range(half));
        end else begin
          b.bin_row = IDX_W'($urandom);
          b.bin_col = IDX_W'($urandom);
        end
        b.bin_real = rand_sample();
        b.bin_imag = rand_sample();
        send_bin(b, 0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS spectral_lowpass_mask");
    end else begin
      $display("FAIL spectral_lowpass_mask");
    end
    $finish;
  end

endmodule
